FILE: sv/hpl_pkg.sv
// Shared types and constants for the head pose block.
// Used by the controller, the datapath, the CORDIC unit, the top level and the testbench.
package hpl_pkg;

  localparam int COORD_W      = 16;
  localparam int ANGLE_W      = 17;
  localparam int SCALE_W      = 24;
  localparam int DEN_W        = 32;
  localparam int CORDIC_STEPS = 21;
  localparam int CORDIC_IDX_W = 5;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd46080;
  localparam logic [SCALE_W-1:0]        SCALE_MAX   = 24'hFFFFFF;
  localparam logic [14:0]               YAW_GAIN    = 15'd23040;
  localparam logic [13:0]               PITCH_GAIN  = 14'd11520;

  localparam logic [21:0] CORDIC_ANGLE [CORDIC_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
    22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4
  };

  localparam logic [1:0] REG_FRAME_W      = 2'd0;
  localparam logic [1:0] REG_FRAME_H      = 2'd1;
  localparam logic [1:0] REG_YAW_LIMIT    = 2'd2;
  localparam logic [1:0] REG_PITCH_LIMIT  = 2'd3;

  localparam logic [1:0] YAW_NONE    = 2'd0;
  localparam logic [1:0] YAW_FRONTAL = 2'd1;
  localparam logic [1:0] YAW_LEFT    = 2'd2;
  localparam logic [1:0] YAW_RIGHT   = 2'd3;
  localparam logic [1:0] PITCH_NONE  = 2'd0;
  localparam logic [1:0] PITCH_UP    = 2'd1;
  localparam logic [1:0] PITCH_DOWN  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP1, ST_PREP2, ST_ISSUE, ST_DIV_YAW, ST_DIV_PITCH,
    ST_DIV_SCALE, ST_SQRT, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_YAW, DIV_PITCH, DIV_SCALE
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     prep1;
    logic     prep2;
    logic     cordic_start;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_yaw;
    logic     cap_pitch;
    logic     sqrt_start;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic sqrt_done;
    logic sqrt_busy;
    logic cordic_busy;
    logic out_free;
  } status_t;

endpackage

FILE: sv/hpl_div.sv
// Restoring divider, one quotient bit per cycle.
// Shared by the yaw, pitch and scale divisions; no package needed.
module hpl_div #(
  parameter int NUM_W = 54,
  parameter int DW    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DW-1:0]    den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  assign trial = {rem, acc[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};
  assign quot  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], fits};
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

FILE: sv/hpl_sqrt.sv
// Integer square root, two radicand bits per cycle.
// Gives floor(sqrt(x)); no package needed.
module hpl_sqrt #(
  parameter int IN_W   = 54,
  parameter int ROOT_W = (IN_W + 1) / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   x,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int SQ_W  = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]   val;
  logic [ROOT_W:0]   rem;
  logic [CNT_W-1:0]  cnt;
  logic [ROOT_W+2:0] cur;
  logic [ROOT_W+2:0] trial;
  logic              fits;

  assign cur   = {rem, val[SQ_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= SQ_W'(x);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[SQ_W-3:0], 2'b00};
      rem  <= fits ? (ROOT_W+1)'(cur - trial) : cur[ROOT_W:0];
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

FILE: sv/hpl_cordic.sv
// Vectoring CORDIC for the eye-line angle, one rotation per cycle.
// Depends on hpl_pkg for the angle table and limits.
module hpl_cordic
  import hpl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [ANGLE_W-1:0] dx,
  input  logic signed [ANGLE_W-1:0] dy,
  output logic                      busy,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int XY_W = 32;

  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [XY_W-1:0]   z;
  logic signed [XY_W-1:0]   base;
  logic [CORDIC_IDX_W-1:0]  step;
  logic signed [XY_W-1:0]   xs;
  logic signed [XY_W-1:0]   ys;
  logic signed [XY_W-1:0]   ang;
  logic signed [XY_W-1:0]   dx_w;
  logic signed [XY_W-1:0]   dy_w;
  logic signed [XY_W-1:0]   sum;
  logic signed [XY_W-1:0]   sh;

  assign dx_w = XY_W'(dx);
  assign dy_w = XY_W'(dy);
  assign xs   = x >>> step;
  assign ys   = y >>> step;
  assign ang  = (step < CORDIC_IDX_W'(CORDIC_STEPS)) ?
                $signed({10'b0, CORDIC_ANGLE[step]}) : '0;
  assign sum  = base + z + 32'sd128;
  assign sh   = sum >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      step <= '0;
      busy <= (dx != '0) && (dy != '0);
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == CORDIC_IDX_W'(CORDIC_STEPS)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z <= '0;
      if (dy == '0) begin
        angle <= dx[ANGLE_W-1] ? ANGLE_LIMIT : '0;
      end else if (dx == '0) begin
        angle <= dy[ANGLE_W-1] ? -17'sd23040 : 17'sd23040;
      end
      if (dx[ANGLE_W-1]) begin
        base <= dy[ANGLE_W-1] ? -32'sd11796480 : 32'sd11796480;
        x    <= (-dx_w) <<< 12;
        y    <= (-dy_w) <<< 12;
      end else begin
        base <= '0;
        x    <= dx_w <<< 12;
        y    <= dy_w <<< 12;
      end
    end else if (busy) begin
      if (step == CORDIC_IDX_W'(CORDIC_STEPS)) begin
        if (sh > 32'sd46080) angle <= ANGLE_LIMIT;
        else if (sh < -32'sd46080) angle <= -ANGLE_LIMIT;
        else angle <= sh[ANGLE_W-1:0];
      end else if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end
    end
  end

endmodule

FILE: sv/hpl_datapath.sv
// Datapath: input and config registers, pose arithmetic, stored pose.
// Depends on hpl_pkg, hpl_div, hpl_sqrt and hpl_cordic.
module hpl_datapath
  import hpl_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic [10*COORD_W-1:0]     in_coords,
  input  logic                      in_complete,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      available,
  output logic signed [ANGLE_W-1:0] pitch_deg,
  output logic signed [15:0]        yaw_deg,
  output logic signed [ANGLE_W-1:0] roll_deg,
  output logic [SCALE_W-1:0]        face_scale,
  output logic signed [15:0]        mid_x,
  output logic signed [15:0]        mid_y,
  output logic signed [15:0]        mid_z,
  output logic [1:0]                yaw_class,
  output logic [1:0]                pitch_class,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata
);

  localparam int EPS      = ((1 << COORD_FRAC_BITS) + 500) / 1000;
  localparam int SCALE_SH = 48 - 2 * COORD_FRAC_BITS;
  localparam int S_W      = 34;
  localparam int NUM_W    = S_W + SCALE_SH;
  localparam int ROOT_W   = (NUM_W + 1) / 2;
  localparam int CMP_W    = (ROOT_W > SCALE_W) ? ROOT_W : SCALE_W;

  // config
  logic [13:0] frame_w;
  logic [13:0] frame_h;
  logic [14:0] yaw_limit;
  logic [13:0] pitch_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w      <= 14'd640;
      frame_h      <= 14'd480;
      yaw_limit    <= 15'd3840;
      pitch_limit  <= 14'd3840;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_FRAME_W:      frame_w      <= pwdata[13:0];
        REG_FRAME_H:      frame_h      <= pwdata[13:0];
        REG_YAW_LIMIT:    yaw_limit    <= pwdata[14:0];
        REG_PITCH_LIMIT:  pitch_limit  <= pwdata[13:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_W:      prdata = 32'(frame_w);
      REG_FRAME_H:      prdata = 32'(frame_h);
      REG_YAW_LIMIT:    prdata = 32'(yaw_limit);
      REG_PITCH_LIMIT:  prdata = 32'(pitch_limit);
    endcase
  end

  // input request
  logic signed [COORD_W-1:0] nx, ny, lx, ly, lz, rx, ry, rz, by, cy;
  logic                      item_complete;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nx <= in_coords[0*COORD_W +: COORD_W];
      ny <= in_coords[1*COORD_W +: COORD_W];
      lx <= in_coords[2*COORD_W +: COORD_W];
      ly <= in_coords[3*COORD_W +: COORD_W];
      lz <= in_coords[4*COORD_W +: COORD_W];
      rx <= in_coords[5*COORD_W +: COORD_W];
      ry <= in_coords[6*COORD_W +: COORD_W];
      rz <= in_coords[7*COORD_W +: COORD_W];
      by <= in_coords[8*COORD_W +: COORD_W];
      cy <= in_coords[9*COORD_W +: COORD_W];
      item_complete <= in_complete;
    end
  end

  // first stage: differences and midpoint
  logic signed [16:0] dnl, dnr;
  logic [15:0]        l_mag, r_mag;
  logic signed [16:0] f_d, c_d, dx, dy, dz;
  logic signed [15:0] mid_x_r, mid_y_r, mid_z_r;
  logic signed [16:0] sum_x, sum_y, sum_z;

  assign dnl   = 17'(nx) - 17'(lx);
  assign dnr   = 17'(nx) - 17'(rx);
  assign sum_x = 17'(lx) + 17'(rx);
  assign sum_y = 17'(ly) + 17'(ry);
  assign sum_z = 17'(lz) + 17'(rz);

  always_ff @(posedge clk) begin
    if (cmd.prep1) begin
      l_mag   <= dnl[16] ? 16'(-dnl) : dnl[15:0];
      r_mag   <= dnr[16] ? 16'(-dnr) : dnr[15:0];
      f_d     <= 17'(by) - 17'(ny);
      c_d     <= 17'(cy) - 17'(ny);
      dx      <= 17'(rx) - 17'(lx);
      dy      <= 17'(ry) - 17'(ly);
      dz      <= 17'(rz) - 17'(lz);
      mid_x_r <= 16'(sum_x >>> 1);
      mid_y_r <= 16'(sum_y >>> 1);
      mid_z_r <= 16'(sum_z >>> 1);
    end
  end

  // second stage: products
  logic signed [16:0] lr_d;
  logic signed [17:0] cf_d;
  logic signed [18:0] pd_c;
  logic [15:0]        lr_mag;
  logic [16:0]        cf_mag;
  logic signed [33:0] sqx, sqy, sqz;
  logic [30:0]        yaw_mag;
  logic [17:0]        yaw_den;
  logic               yaw_neg;
  logic [30:0]        pn_mag;
  logic               pn_neg;
  logic               pn_zero;
  logic signed [18:0] pd;
  logic [31:0]        sq_x, sq_y, sq_z;
  logic [28:0]        img_den;

  assign lr_d   = 17'(l_mag) - 17'(r_mag);
  assign lr_mag = lr_d[16] ? 16'(-lr_d) : lr_d[15:0];
  assign cf_d   = 18'(c_d) - 18'(f_d);
  assign cf_mag = cf_d[17] ? 17'(-cf_d) : cf_d[16:0];
  assign pd_c   = 19'(c_d) + 19'(f_d) + 19'(EPS);
  assign sqx    = dx * dx;
  assign sqy    = dy * dy;
  assign sqz    = dz * dz;

  always_ff @(posedge clk) begin
    if (cmd.prep2) begin
      yaw_mag <= 31'(lr_mag) * 31'(YAW_GAIN);
      yaw_den <= 18'(l_mag) + 18'(r_mag) + 18'(EPS);
      yaw_neg <= lr_d[16];
      pn_mag  <= 31'(cf_mag) * 31'(PITCH_GAIN);
      pn_neg  <= cf_d[17];
      pn_zero <= cf_d == '0;
      pd      <= pd_c;
      sq_x    <= sqx[31:0];
      sq_y    <= sqy[31:0];
      sq_z    <= sqz[31:0];
      img_den <= 29'(28'(frame_w) * 28'(frame_w))
               + 29'(28'(frame_h) * 28'(frame_h));
    end
  end

  // divider operands
  logic [18:0]        pd_abs;
  logic [S_W-1:0]     s_sum;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   quot;
  logic               div_busy, div_done;

  assign pd_abs = pd[18] ? 19'(-pd) : 19'(pd);
  assign s_sum  = 34'(sq_x) + 34'(sq_y) + 34'(sq_z);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_YAW: begin
        div_num = NUM_W'({yaw_mag, 1'b0}) + NUM_W'(yaw_den);
        div_den = DEN_W'({yaw_den, 1'b0});
      end
      DIV_PITCH: begin
        div_num = NUM_W'({pn_mag, 1'b0}) + NUM_W'(pd_abs);
        div_den = DEN_W'({pd_abs, 1'b0});
      end
      DIV_SCALE: begin
        div_num = NUM_W'(s_sum) << SCALE_SH;
        div_den = DEN_W'(img_den);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  hpl_div #(.NUM_W(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  logic [ROOT_W-1:0] root;
  logic              sqrt_busy, sqrt_done;

  hpl_sqrt #(.IN_W(NUM_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .x     (quot),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (root)
  );

  logic signed [ANGLE_W-1:0] roll_c;
  logic                      cordic_busy;

  hpl_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cordic_start),
    .dx    (dx),
    .dy    (dy),
    .busy  (cordic_busy),
    .angle (roll_c)
  );

  // quotient capture
  logic signed [ANGLE_W-1:0] yaw_res, pitch_res;
  logic [ANGLE_W-1:0]        pq;

  assign pq = (quot > NUM_W'(ANGLE_LIMIT)) ? ANGLE_LIMIT : quot[ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_yaw) begin
      yaw_res <= yaw_neg ? -$signed(quot[ANGLE_W-1:0]) : $signed(quot[ANGLE_W-1:0]);
    end
    if (cmd.cap_pitch) begin
      if (pd == '0) begin
        pitch_res <= pn_zero ? '0 : (pn_neg ? -ANGLE_LIMIT : ANGLE_LIMIT);
      end else begin
        pitch_res <= (pn_neg != pd[18]) ? -$signed(pq) : $signed(pq);
      end
    end
  end

  // result and stored pose
  logic [SCALE_W-1:0]        scale_res;
  logic signed [ANGLE_W:0]   yaw_w, yaw_abs, yl;
  logic signed [ANGLE_W:0]   pitch_w, pl;
  logic [1:0]                yc, pc;
  logic signed [ANGLE_W-1:0] kept_yaw;
  logic                      out_free;

  always_comb begin
    if (img_den == '0) begin
      scale_res = (s_sum != '0) ? SCALE_MAX : '0;
    end else if (CMP_W'(root) > CMP_W'(SCALE_MAX)) begin
      scale_res = SCALE_MAX;
    end else begin
      scale_res = SCALE_W'(root);
    end
  end

  assign yaw_w   = 18'(yaw_res);
  assign yaw_abs = yaw_w[ANGLE_W] ? -yaw_w : yaw_w;
  assign yl      = $signed(18'(yaw_limit));
  assign pitch_w = 18'(pitch_res);
  assign pl      = $signed(18'(pitch_limit));

  always_comb begin
    priority if (yaw_abs < yl) yc = YAW_FRONTAL;
    else if (yaw_w < -yl) yc = YAW_LEFT;
    else if (yaw_w > yl) yc = YAW_RIGHT;
    else yc = YAW_NONE;
  end

  always_comb begin
    priority if (pitch_w < -pl) pc = PITCH_UP;
    else if (pitch_w > pl) pc = PITCH_DOWN;
    else pc = PITCH_NONE;
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      available   <= 1'b0;
      yaw_class   <= YAW_NONE;
      pitch_class <= PITCH_NONE;
      pitch_deg   <= '0;
      kept_yaw    <= '0;
      roll_deg    <= '0;
      face_scale  <= '0;
      mid_x       <= '0;
      mid_y       <= '0;
      mid_z       <= '0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        available <= item_complete;
        if (item_complete) begin
          yaw_class   <= yc;
          pitch_class <= pc;
          pitch_deg   <= pitch_res;
          kept_yaw    <= yaw_res;
          roll_deg    <= roll_c;
          face_scale  <= scale_res;
          mid_x       <= mid_x_r;
          mid_y       <= mid_y_r;
          mid_z       <= mid_z_r;
        end else begin
          yaw_class   <= YAW_NONE;
          pitch_class <= PITCH_NONE;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign yaw_deg = kept_yaw[15:0];

  assign status.div_done    = div_done;
  assign status.div_busy    = div_busy;
  assign status.sqrt_done   = sqrt_done;
  assign status.sqrt_busy   = sqrt_busy;
  assign status.cordic_busy = cordic_busy;
  assign status.out_free    = out_free;

endmodule

FILE: sv/hpl_ctrl.sv
// Controller state machine sequencing the pose datapath.
// Depends on hpl_pkg for the state, command and status types.
module hpl_ctrl
  import hpl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_complete,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = in_complete ? ST_PREP1 : ST_FINISH;
      end
      ST_PREP1:     state_next = ST_PREP2;
      ST_PREP2:     state_next = ST_ISSUE;
      ST_ISSUE:     state_next = ST_DIV_YAW;
      ST_DIV_YAW:   if (status.div_done) state_next = ST_DIV_PITCH;
      ST_DIV_PITCH: if (status.div_done) state_next = ST_DIV_SCALE;
      ST_DIV_SCALE: if (status.div_done) state_next = ST_SQRT;
      ST_SQRT:      if (status.sqrt_done) state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free && !status.cordic_busy) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_YAW;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PREP1: cmd.prep1 = 1'b1;
      ST_PREP2: cmd.prep2 = 1'b1;
      ST_ISSUE: begin
        cmd.cordic_start = 1'b1;
        cmd.div_start    = 1'b1;
        cmd.div_sel      = DIV_YAW;
      end
      ST_DIV_YAW: begin
        cmd.cap_yaw   = status.div_done;
        cmd.div_start = status.div_done;
        cmd.div_sel   = DIV_PITCH;
      end
      ST_DIV_PITCH: begin
        cmd.cap_pitch = status.div_done;
        cmd.div_start = status.div_done;
        cmd.div_sel   = DIV_SCALE;
      end
      ST_DIV_SCALE: cmd.sqrt_start = status.div_done;
      ST_SQRT: ;
      ST_FINISH: cmd.finish = status.out_free && !status.cordic_busy;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free && !status.cordic_busy)
    else $error("result written while output or cordic busy");
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");
  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.div_busy && !status.sqrt_busy && !status.cordic_busy)
    else $error("request taken while arithmetic busy");
`endif

endmodule

FILE: sv/head_pose_from_landmarks.sv
// Head pose from five face landmarks: stream in, stream out, APB config.
// Complete item: two prep stages, then yaw, pitch and scale divisions on the shared
// one-bit-per-cycle divider beside the CORDIC roll, and a square root for the scale.
// Incomplete item: the result is written without arithmetic once the output is free. One item at
// a time; the next request is taken while the previous result waits. Synchronous reset:
// config to defaults, stored pose cleared, no pending result.
module head_pose_from_landmarks
  import hpl_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // nose_x, nose_y, left_eye_x, left_eye_y, left_eye_z, right_eye_x,
  // right_eye_y, right_eye_z, brow_y, chin_y (16 bits each)
  input  logic [159:0] s_axis_tdata,
  // complete
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pitch_deg 17, yaw_deg 16, roll_deg 17, face_scale 24, mid_x 16,
  // mid_y 16, mid_z 16, zero pad 6
  output logic [127:0] m_axis_tdata,
  // available 1, yaw_class 2, pitch_class 2
  output logic [4:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cmd_t    cmd;
  status_t status;

  logic                      available;
  logic signed [ANGLE_W-1:0] pitch_deg, roll_deg;
  logic signed [15:0]        yaw_deg, mid_x, mid_y, mid_z;
  logic [SCALE_W-1:0]        face_scale;
  logic [1:0]                yaw_class, pitch_class;

  assign pready = 1'b1;

  hpl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_complete (s_axis_tuser[0]),
    .in_ready    (s_axis_tready),
    .status      (status),
    .cmd         (cmd)
  );

  hpl_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_coords   (s_axis_tdata),
    .in_complete (s_axis_tuser[0]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .available   (available),
    .pitch_deg   (pitch_deg),
    .yaw_deg     (yaw_deg),
    .roll_deg    (roll_deg),
    .face_scale  (face_scale),
    .mid_x       (mid_x),
    .mid_y       (mid_y),
    .mid_z       (mid_z),
    .yaw_class   (yaw_class),
    .pitch_class (pitch_class),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

  assign m_axis_tdata = {6'b0, mid_z, mid_y, mid_x, face_scale, roll_deg,
                         yaw_deg, pitch_deg};
  assign m_axis_tuser = {pitch_class, yaw_class, available};

endmodule

FILE: tb/tb_head_pose_from_landmarks.sv
// Self-checking testbench for head_pose_from_landmarks: random stream traffic
// with stalls on both sides, APB register phases, built-in pose predictor.
// Depends on hpl_pkg and the head_pose_from_landmarks RTL only.
module tb_head_pose_from_landmarks
  import hpl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] chin_y, brow_y;
    logic signed [15:0] right_eye_z, right_eye_y, right_eye_x;
    logic signed [15:0] left_eye_z, left_eye_y, left_eye_x;
    logic signed [15:0] nose_y, nose_x;
  } marks_t;

  typedef struct packed {
    logic               complete;
    marks_t             marks;
  } request_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic signed [15:0] mid_z, mid_y, mid_x;
    logic [23:0]        face_scale;
    logic signed [16:0] roll_deg;
    logic signed [15:0] yaw_deg;
    logic signed [16:0] pitch_deg;
  } pose_data_t;

  typedef struct packed {
    logic [1:0] pitch_class;
    logic [1:0] yaw_class;
    logic       available;
  } pose_user_t;

  typedef struct packed {
    pose_user_t user;
    pose_data_t data;
  } pose_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [127:0] m_axis_tdata;
  logic [4:0] m_axis_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  head_pose_from_landmarks dut (.*);

  always #10 clk = ~clk;

  // predictor state
  longint unsigned img_w = 640, img_h = 480, yaw_lim = 3840, pitch_lim = 3840;
  logic pose_valid = 0;
  longint kept_pitch = 0, kept_yaw = 0, kept_roll = 0, kept_mid_x = 0;
  longint kept_mid_y = 0, kept_mid_z = 0;
  longint unsigned kept_scale = 0;

  request_t pending_reqs[$];
  pose_t expected_poses[$];
  int errors = 0;
  bit no_idle = 0;
  bit req_taken = 0;
  int send_gap = 0, recv_stall = 0, quiet_cycles = 0;

  function automatic longint near_div(longint n, longint d);
    longint an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint clamp_deg(longint v);
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) return -ANGLE_LIMIT;
    return v;
  endfunction

  function automatic longint eye_line_deg(longint dx, longint dy);
    longint base, x, y, z, xs, ys;
    base = 0;
    z = 0;
    if (dy == 0) return dx < 0 ? 180 * 256 : 0;
    if (dx == 0) return dy > 0 ? 90 * 256 : -90 * 256;
    if (dx < 0) begin
      base = dy > 0 ? 180 * 65536 : -180 * 65536;
      dx = -dx;
      dy = -dy;
    end
    x = dx * 4096;
    y = dy * 4096;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(CORDIC_ANGLE[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(CORDIC_ANGLE[i]);
      end
    end
    return clamp_deg((base + z + 128) >>> 8);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned q);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned eye_scale(longint dx, longint dy, longint dz);
    longint unsigned s, den, r;
    s = dx * dx + dy * dy + dz * dz;
    den = img_w * img_w + img_h * img_h;
    if (den == 0) return s != 0 ? SCALE_MAX : 0;
    r = int_sqrt((s << 20) / den);
    return r > SCALE_MAX ? SCALE_MAX : r;
  endfunction

  function pose_t predict_pose(request_t rq);
    pose_t p;
    longint nx, ny, lx, ly, lz, rx, ry, rz, by, cy, l, r, f, c, pd, pn;
    p = '0;
    if (rq.complete) begin
      nx = rq.marks.nose_x; ny = rq.marks.nose_y;
      lx = rq.marks.left_eye_x; ly = rq.marks.left_eye_y; lz = rq.marks.left_eye_z;
      rx = rq.marks.right_eye_x; ry = rq.marks.right_eye_y; rz = rq.marks.right_eye_z;
      by = rq.marks.brow_y; cy = rq.marks.chin_y;
      l = nx > lx ? nx - lx : lx - nx;
      r = nx > rx ? nx - rx : rx - nx;
      f = by - ny;
      c = cy - ny;
      pd = c + f + 16;
      pn = (c - f) * 11520;
      kept_yaw = near_div((l - r) * 23040, l + r + 16);
      if (pd == 0) kept_pitch = pn > 0 ? ANGLE_LIMIT : (pn < 0 ? -ANGLE_LIMIT : 0);
      else kept_pitch = clamp_deg(near_div(pn, pd));
      kept_roll = eye_line_deg(rx - lx, ry - ly);
      kept_scale = eye_scale(rx - lx, ry - ly, rz - lz);
      kept_mid_x = (lx + rx) >>> 1;
      kept_mid_y = (ly + ry) >>> 1;
      kept_mid_z = (lz + rz) >>> 1;
      pose_valid = 1;
      if ((kept_yaw < 0 ? -kept_yaw : kept_yaw) < longint'(yaw_lim))
        p.user.yaw_class = YAW_FRONTAL;
      else if (kept_yaw < -longint'(yaw_lim)) p.user.yaw_class = YAW_LEFT;
      else if (kept_yaw > longint'(yaw_lim)) p.user.yaw_class = YAW_RIGHT;
      else p.user.yaw_class = YAW_NONE;
      if (kept_pitch < -longint'(pitch_lim)) p.user.pitch_class = PITCH_UP;
      else if (kept_pitch > longint'(pitch_lim)) p.user.pitch_class = PITCH_DOWN;
      else p.user.pitch_class = PITCH_NONE;
    end else begin
      pose_valid = 0;
    end
    p.user.available = pose_valid;
    p.data.pitch_deg = kept_pitch[16:0];
    p.data.yaw_deg = kept_yaw[15:0];
    p.data.roll_deg = kept_roll[16:0];
    p.data.face_scale = kept_scale[23:0];
    p.data.mid_x = kept_mid_x[15:0];
    p.data.mid_y = kept_mid_y[15:0];
    p.data.mid_z = kept_mid_z[15:0];
    return p;
  endfunction

  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (no_idle || k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  function automatic logic signed [15:0] near_val(int center, int spread);
    return 16'(center + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int k;
    rq = 161'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    k = $urandom_range(0, 99);
    rq.complete = k >= 12;
    if (k >= 30) begin
      rq.marks.nose_x = near_val(0, 4000);
      rq.marks.nose_y = near_val(0, 3000);
      rq.marks.left_eye_x = near_val(-4000, 3000);
      rq.marks.right_eye_x = near_val(4000, 3000);
      rq.marks.left_eye_y = near_val(-2000, 1500);
      rq.marks.right_eye_y = near_val(-2000, 1500);
      rq.marks.left_eye_z = near_val(0, 2000);
      rq.marks.right_eye_z = near_val(0, 2000);
      rq.marks.brow_y = near_val(-6000, 4000);
      rq.marks.chin_y = near_val(6000, 4000);
      if (k >= 95) rq.marks.right_eye_y = rq.marks.left_eye_y;
      else if (k >= 90) rq.marks.right_eye_x = rq.marks.left_eye_x;
    end
    return rq;
  endfunction

  function automatic request_t make_request(logic cmp, int nx, int ny, int lx, int ly,
                                            int lz, int rx, int ry, int rz, int by, int cy);
    request_t rq;
    rq.complete = cmp;
    rq.marks = {16'(cy), 16'(by), 16'(rz), 16'(ry), 16'(rx), 16'(lz), 16'(ly), 16'(lx),
                16'(ny), 16'(nx)};
    return rq;
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_FRAME_W: img_w = value & 32'h3FFF;
      REG_FRAME_H: img_h = value & 32'h3FFF;
      REG_YAW_LIMIT: yaw_lim = value & 32'h7FFF;
      default: pitch_lim = value & 32'h3FFF;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_poses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_poses.push_back(predict_pose(pending_reqs.pop_front()));
      req_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || req_taken)) begin
      if (req_taken) send_gap = idle_len();
      req_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 0;
      end else if (pending_reqs.size() != 0) begin
        s_axis_tvalid <= 1;
        {s_axis_tuser, s_axis_tdata} <= pending_reqs[0];
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      m_axis_tready <= 0;
    end else begin
      recv_stall = idle_len();
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    pose_t want, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.user = m_axis_tuser;
      got.data = m_axis_tdata;
      if (expected_poses.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = expected_poses.pop_front();
        if (got.user.available !== want.user.available) begin
          $error("available exp %0d got %0d", want.user.available, got.user.available);
          errors++;
        end
        if (got.user.yaw_class !== want.user.yaw_class) begin
          $error("yaw_class exp %0d got %0d", want.user.yaw_class, got.user.yaw_class);
          errors++;
        end
        if (got.user.pitch_class !== want.user.pitch_class) begin
          $error("pitch_class exp %0d got %0d", want.user.pitch_class, got.user.pitch_class);
          errors++;
        end
        if (got.data.pitch_deg !== want.data.pitch_deg) begin
          $error("pitch_deg exp %0d got %0d", want.data.pitch_deg, got.data.pitch_deg);
          errors++;
        end
        if (got.data.yaw_deg !== want.data.yaw_deg) begin
          $error("yaw_deg exp %0d got %0d", want.data.yaw_deg, got.data.yaw_deg);
          errors++;
        end
        if (got.data.roll_deg !== want.data.roll_deg) begin
          $error("roll_deg exp %0d got %0d", want.data.roll_deg, got.data.roll_deg);
          errors++;
        end
        if (got.data.face_scale !== want.data.face_scale) begin
          $error("face_scale exp %0d got %0d", want.data.face_scale, got.data.face_scale);
          errors++;
        end
        if (got.data.mid_x !== want.data.mid_x) begin
          $error("mid_x exp %0d got %0d", want.data.mid_x, got.data.mid_x);
          errors++;
        end
        if (got.data.mid_y !== want.data.mid_y) begin
          $error("mid_y exp %0d got %0d", want.data.mid_y, got.data.mid_y);
          errors++;
        end
        if (got.data.mid_z !== want.data.mid_z) begin
          $error("mid_z exp %0d got %0d", want.data.mid_z, got.data.mid_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL head_pose_from_landmarks");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, axes of the eye line, zero pitch divisor, incomplete items
    pending_reqs.push_back(make_request(0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10));
    pending_reqs.push_back(make_request(1, 0, 0, -4000, -2000, 100, 4000, -2000, -100,
                                        -6000, 6000));
    pending_reqs.push_back(make_request(1, 0, 0, 4000, 0, 0, -4000, 0, 0, -6000, 6000));
    pending_reqs.push_back(make_request(1, 0, 0, 0, -3000, 0, 0, 3000, 0, -6000, 6000));
    pending_reqs.push_back(make_request(1, 0, 0, 0, 3000, 0, 0, -3000, 0, -6000, 6000));
    pending_reqs.push_back(make_request(1, 0, 0, 5, 5, 5, 5, 5, 5, -6000, 6000));
    pending_reqs.push_back(make_request(1, 0, 0, -100, 0, 0, 100, 0, 0, -8, -8));
    pending_reqs.push_back(make_request(1, 0, 0, -100, 0, 0, 100, 0, 0, -20, 4));
    pending_reqs.push_back(make_request(1, 0, 0, -100, 0, 0, 100, 0, 0, 4, -20));
    pending_reqs.push_back(make_request(0, -32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_request(1, 32767, 32767, -32768, -32768, -32768,
                                        32767, 32767, 32767, -32768, 32767));
    pending_reqs.push_back(make_request(1, -32768, -32768, 32767, 32767, 32767,
                                        -32768, -32768, -32768, 32767, -32768));
    pending_reqs.push_back(make_request(1, 3000, 0, -4000, 0, 0, 4000, 0, 0, -6000, 6000));
    pending_reqs.push_back(make_request(1, -3000, 2000, -4000, 100, 0, 4000, -100, 0,
                                        -6000, 6000));
    pending_reqs.push_back(make_request(1, 0, 3000, -4000, -50, 0, 4000, 60, 0, -2000, 9000));
    pending_reqs.push_back(make_request(1, 0, -3000, -4000, 0, 0, 4000, 0, 0, -9000, 2000));
    pending_reqs.push_back(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_request(1, -1, -1, -1, -1, -1, 0, -1, 0, -1, -1));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          apb_write(REG_FRAME_W, 1); apb_write(REG_FRAME_H, 1);
          apb_write(REG_YAW_LIMIT, 0); apb_write(REG_PITCH_LIMIT, 0);
        end
        2: begin
          apb_write(REG_FRAME_W, 8192); apb_write(REG_FRAME_H, 8192);
          apb_write(REG_YAW_LIMIT, 23040); apb_write(REG_PITCH_LIMIT, 11520);
        end
        3: begin
          apb_write(REG_FRAME_W, 0); apb_write(REG_FRAME_H, 0);
          apb_write(REG_YAW_LIMIT, 32'hFFFF_FFFF); apb_write(REG_PITCH_LIMIT, 32'hFFFF_FFFF);
        end
        4: begin
          apb_write(REG_FRAME_W, $urandom_range(1, 8192));
          apb_write(REG_FRAME_H, $urandom_range(1, 8192));
          apb_write(REG_YAW_LIMIT, $urandom_range(0, 23040));
          apb_write(REG_PITCH_LIMIT, $urandom_range(0, 11520));
        end
        default: begin
          apb_write(REG_FRAME_W, 640); apb_write(REG_FRAME_H, 480);
          apb_write(REG_YAW_LIMIT, 3840); apb_write(REG_PITCH_LIMIT, 3840);
        end
      endcase
      no_idle = (ph == 2);
      for (int n = 0; n < 100; n++) pending_reqs.push_back(random_request());
      drain();
    end

    repeat (800) @(posedge clk);
    if (errors == 0 && expected_poses.size() == 0)
      $display("PASS head_pose_from_landmarks");
    else
      $display("FAIL head_pose_from_landmarks");
    $finish;
  end
endmodule
